FILE: src/dsac_pkg.sv
// shared types, constants and register codes for the dual sensor average and classify block
`default_nettype none

package dsac_pkg;

    // field widths fixed by the item format
    localparam int SAMPLE_FIELD_BITS = 12;
    localparam int LEVEL_BITS        = 12;
    localparam int CODE_BITS         = 2;
    localparam int CFG_INDEX_BITS    = 3;

    // defaults for the top level parameters
    localparam int WINDOW_LEN_DEF  = 5;
    localparam int SAMPLE_BITS_DEF = 12;

    // threshold levels after reset
    localparam logic [LEVEL_BITS-1:0] MOIST_DRY_RESET    = 12'd1500;
    localparam logic [LEVEL_BITS-1:0] MOIST_WET_RESET    = 12'd3000;
    localparam logic [LEVEL_BITS-1:0] LIGHT_DARK_RESET   = 12'd1000;
    localparam logic [LEVEL_BITS-1:0] LIGHT_BRIGHT_RESET = 12'd3000;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MOIST_DRY    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MOIST_WET    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LIGHT_DARK   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LIGHT_BRIGHT = 3'd3;

    typedef enum logic [CODE_BITS-1:0] {
        BAND_LOW  = 2'd0,
        BAND_MID  = 2'd1,
        BAND_HIGH = 2'd2
    } t_band;

    typedef enum logic [CODE_BITS-1:0] {
        PLANT_HAPPY    = 2'd0,
        PLANT_STRESSED = 2'd1,
        PLANT_ALERT    = 2'd2,
        PLANT_NEUTRAL  = 2'd3
    } t_plant;

    typedef enum logic [CODE_BITS-1:0] {
        PAT_HAPPY   = 2'd0,
        PAT_RELAXED = 2'd1,
        PAT_NEUTRAL = 2'd2,
        PAT_ALERT   = 2'd3
    } t_pattern;

    typedef struct packed {
        logic [SAMPLE_FIELD_BITS-1:0] moisture_sample;
        logic [SAMPLE_FIELD_BITS-1:0] light_sample;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] moisture_average;
        logic [LEVEL_BITS-1:0] light_average;
        logic [CODE_BITS-1:0]  moisture_band;
        logic [CODE_BITS-1:0]  light_band;
        logic [CODE_BITS-1:0]  plant_state;
        logic [CODE_BITS-1:0]  pattern_code;
    } t_out_item;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] low;
        logic [LEVEL_BITS-1:0] high;
    } t_levels;

    // stage loads handed to each lane
    typedef struct packed {
        logic accept;
        logic load_mul;
        logic load_band;
    } t_lane_ctrl;

endpackage

`default_nettype wire

FILE: src/dsac_lane.sv
// one sensor lane: sample window, running sum, divide by window length, band compare
`default_nettype none

module dsac_lane #(
    parameter int WINDOW_LEN  = dsac_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = dsac_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire dsac_pkg::t_lane_ctrl                   i_ctrl,
    input  wire logic [$clog2(WINDOW_LEN)-1:0]          i_wpos,
    input  wire logic [dsac_pkg::SAMPLE_FIELD_BITS-1:0] i_sample,
    input  wire dsac_pkg::t_levels                      i_levels,
    output logic [dsac_pkg::LEVEL_BITS-1:0]             o_average,
    output dsac_pkg::t_band                             o_band
);
    import dsac_pkg::*;

    // sum fits sample bits plus log2 of the window
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int SHIFT   = SUM_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int CMP_W   = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
    // rounded-up reciprocal, exact quotient for every sum below 2**SUM_W
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP[RECIP_W-1:0];

    logic [SAMPLE_BITS-1:0] r_window [WINDOW_LEN];
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       n_sum;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic [PROD_W-1:0]      r_prod;
    logic [SAMPLE_BITS-1:0] w_quot;
    logic [CMP_W-1:0]       w_quot_x;
    logic [LEVEL_BITS-1:0]  r_avg;
    t_band                  r_band;
    t_band                  n_band;

    assign w_sample = SAMPLE_BITS'(i_sample);
    // replace the oldest entry in the sum
    assign n_sum    = r_sum - SUM_W'(r_window[i_wpos]) + SUM_W'(w_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_LEN; k++) begin
                r_window[k] <= '0;
            end
            r_sum <= '0;
        end else if (i_ctrl.accept) begin
            r_window[i_wpos] <= w_sample;
            r_sum            <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_mul) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(RECIP_V);
        end
    end

    assign w_quot   = r_prod[SHIFT +: SAMPLE_BITS];
    assign w_quot_x = CMP_W'(w_quot);

    // low threshold checked first
    always_comb begin
        if (w_quot_x < CMP_W'(i_levels.low)) begin
            n_band = BAND_LOW;
        end else if (w_quot_x > CMP_W'(i_levels.high)) begin
            n_band = BAND_HIGH;
        end else begin
            n_band = BAND_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_band) begin
            r_avg  <= w_quot_x[LEVEL_BITS-1:0];
            r_band <= n_band;
        end
    end

    assign o_average = r_avg;
    assign o_band    = r_band;

endmodule

`default_nettype wire

FILE: src/dsac_merge.sv
// merge stage: plant state and pattern from both bands, output register
`default_nettype none

module dsac_merge (
    input  wire logic                          i_clk,
    input  wire logic                          i_load,
    input  wire logic [dsac_pkg::LEVEL_BITS-1:0] i_m_average,
    input  wire logic [dsac_pkg::LEVEL_BITS-1:0] i_l_average,
    input  wire dsac_pkg::t_band               i_m_band,
    input  wire dsac_pkg::t_band               i_l_band,
    output dsac_pkg::t_out_item                o_item
);
    import dsac_pkg::*;

    t_plant    w_state;
    t_pattern  w_pattern;
    t_out_item r_item;

    always_comb begin
        if (i_m_band == BAND_MID && i_l_band != BAND_LOW) begin
            w_state = PLANT_HAPPY;
        end else if (i_m_band == BAND_LOW || i_l_band == BAND_LOW) begin
            w_state = PLANT_STRESSED;
        end else if (i_m_band == BAND_HIGH) begin
            w_state = PLANT_ALERT;
        end else begin
            w_state = PLANT_NEUTRAL;
        end
    end

    always_comb begin
        case (w_state)
            PLANT_HAPPY:    w_pattern = PAT_HAPPY;
            PLANT_STRESSED,
            PLANT_ALERT:    w_pattern = PAT_ALERT;
            default: begin
                w_pattern = (i_m_band == BAND_MID) ? PAT_RELAXED : PAT_NEUTRAL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item.moisture_average <= i_m_average;
            r_item.light_average    <= i_l_average;
            r_item.moisture_band    <= i_m_band;
            r_item.light_band       <= i_l_band;
            r_item.plant_state      <= w_state;
            r_item.pattern_code     <= w_pattern;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

FILE: src/dual_sensor_average_and_classify.sv
// throughput: one item per cycle; each stage moves on when the one after it is empty or moving
// stages: running-sum window update, reciprocal multiply, band compare, classify and output reg
// reset (sync, active low) clears both windows, running sums, write position and stage valids,
// and loads the four threshold levels with their defaults; no clearing pass is needed
`default_nettype none

module dual_sensor_average_and_classify #(
    parameter int WINDOW_LEN  = dsac_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = dsac_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input item channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire dsac_pkg::t_in_item                  i_in_item,
    // result item channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output dsac_pkg::t_out_item                      o_out_item,
    // configuration writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [dsac_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [dsac_pkg::LEVEL_BITS-1:0]     i_cfg_data
);
    import dsac_pkg::*;

    localparam int WPOS_W = $clog2(WINDOW_LEN);
    localparam logic [WPOS_W-1:0] WPOS_LAST = WPOS_W'(WINDOW_LEN - 1);

    // threshold registers, one pair per lane
    t_levels r_moist_levels;
    t_levels r_light_levels;

    // shared write position for both windows
    logic [WPOS_W-1:0] r_wpos;

    // stage valid bits: sum, product, band, output
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;

    // a stage may load when it is empty or its item moves on this cycle
    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;
    logic w_rdy4;
    logic w_accept;

    t_lane_ctrl w_lane_ctrl;

    logic [LEVEL_BITS-1:0] w_m_average;
    logic [LEVEL_BITS-1:0] w_l_average;
    t_band                 w_m_band;
    t_band                 w_l_band;

    assign w_rdy4   = !r_v4 || !i_out_stall;
    assign w_rdy3   = !r_v3 || w_rdy4;
    assign w_rdy2   = !r_v2 || w_rdy3;
    assign w_rdy1   = !r_v1 || w_rdy2;
    assign w_accept = i_in_valid && w_rdy1;

    assign o_in_stall  = !w_rdy1;
    assign o_out_valid = r_v4;
    // the user must change levels only between items; the block does not enforce it, so writes are always taken
    assign o_cfg_ready = 1'b1;

    assign w_lane_ctrl.accept    = w_accept;
    assign w_lane_ctrl.load_mul  = w_rdy2 && r_v1;
    assign w_lane_ctrl.load_band = w_rdy3 && r_v2;

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // write position wraps after the last window entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
        end else if (w_accept) begin
            r_wpos <= (r_wpos == WPOS_LAST) ? '0 : r_wpos + WPOS_W'(1);
        end
    end

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moist_levels.low  <= MOIST_DRY_RESET;
            r_moist_levels.high <= MOIST_WET_RESET;
            r_light_levels.low  <= LIGHT_DARK_RESET;
            r_light_levels.high <= LIGHT_BRIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MOIST_DRY:    r_moist_levels.low  <= i_cfg_data;
                CFG_MOIST_WET:    r_moist_levels.high <= i_cfg_data;
                CFG_LIGHT_DARK:   r_light_levels.low  <= i_cfg_data;
                CFG_LIGHT_BRIGHT: r_light_levels.high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // moisture lane
    dsac_lane #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_moist_lane (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_lane_ctrl),
        .i_wpos    (r_wpos),
        .i_sample  (i_in_item.moisture_sample),
        .i_levels  (r_moist_levels),
        .o_average (w_m_average),
        .o_band    (w_m_band)
    );

    // light lane
    dsac_lane #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_light_lane (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_lane_ctrl),
        .i_wpos    (r_wpos),
        .i_sample  (i_in_item.light_sample),
        .i_levels  (r_light_levels),
        .o_average (w_l_average),
        .o_band    (w_l_band)
    );

    // combine both bands into the result item
    dsac_merge u_merge (
        .i_clk       (i_clk),
        .i_load      (w_rdy4 && r_v3),
        .i_m_average (w_m_average),
        .i_l_average (w_l_average),
        .i_m_band    (w_m_band),
        .i_l_band    (w_l_band),
        .o_item      (o_out_item)
    );

    // an accepted item always lands in the sum stage
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_v1)
        else $error("accepted item lost before sum stage");

    // write position stays inside the window
    a_wpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= WPOS_LAST)
        else $error("write position beyond window");

    // a blocked band stage keeps its item
    a_band_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !w_rdy3 |=> r_v3)
        else $error("band stage item dropped while blocked");

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

`default_nettype wire

FILE: verif/dual_sensor_average_and_classify_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the dual sensor average and classify block

module dual_sensor_average_and_classify_test;
    import dsac_pkg::*;

    localparam int WIN_LEN       = WINDOW_LEN_DEF;
    localparam int CYCLE_LIMIT   = 800000;  // well above the slowest legal run
    localparam int SETTLE_CYCLES = 8;       // well past the pipeline latency
    localparam int IDLE_LIMIT    = 20000;
    localparam logic [LEVEL_BITS-1:0]        LEVEL_MAX  = '1;
    localparam logic [SAMPLE_FIELD_BITS-1:0] SAMPLE_MAX = '1;

    // ---------------------------------------------------------------
    // scoreboard: tracks both sample windows and the threshold levels,
    // predicts each result item and checks the ones the block emits
    // ---------------------------------------------------------------
    class average_scoreboard;
        logic [SAMPLE_FIELD_BITS-1:0] moist_win [WIN_LEN];
        logic [SAMPLE_FIELD_BITS-1:0] light_win [WIN_LEN];
        int unsigned                  wr_pos;
        t_levels                      moist_lv;
        t_levels                      light_lv;
        t_out_item                    expected_q [$];
        int unsigned                  fail_count;

        function new();
            foreach (moist_win[i]) begin
                moist_win[i] = '0;
                light_win[i] = '0;
            end
            wr_pos        = 0;
            moist_lv.low  = MOIST_DRY_RESET;
            moist_lv.high = MOIST_WET_RESET;
            light_lv.low  = LIGHT_DARK_RESET;
            light_lv.high = LIGHT_BRIGHT_RESET;
            fail_count    = 0;
        endfunction

        function void write_level(logic [CFG_INDEX_BITS-1:0] idx, logic [LEVEL_BITS-1:0] val);
            case (idx)
                CFG_MOIST_DRY:    moist_lv.low  = val;
                CFG_MOIST_WET:    moist_lv.high = val;
                CFG_LIGHT_DARK:   light_lv.low  = val;
                CFG_LIGHT_BRIGHT: light_lv.high = val;
                default: ;  // unknown index leaves every level alone
            endcase
        endfunction

        // low threshold wins when the two levels are crossed
        function t_band classify_mean(logic [LEVEL_BITS-1:0] mean, t_levels lv);
            if (mean < lv.low)
                return BAND_LOW;
            if (mean > lv.high)
                return BAND_HIGH;
            return BAND_MID;
        endfunction

        function void note_input(t_in_item it);
            int unsigned msum;
            int unsigned lsum;
            t_out_item   want;
            t_band       mb;
            t_band       lb;
            t_plant      ps;
            t_pattern    pc;
            moist_win[wr_pos] = it.moisture_sample;
            light_win[wr_pos] = it.light_sample;
            wr_pos = (wr_pos + 1 >= WIN_LEN) ? 0 : wr_pos + 1;
            msum = 0;
            lsum = 0;
            for (int i = 0; i < WIN_LEN; i++) begin
                msum += moist_win[i];
                lsum += light_win[i];
            end
            // warm-up entries stay zero but still count in the divide
            want.moisture_average = LEVEL_BITS'(msum / WIN_LEN);
            want.light_average    = LEVEL_BITS'(lsum / WIN_LEN);
            mb = classify_mean(want.moisture_average, moist_lv);
            lb = classify_mean(want.light_average, light_lv);
            if (mb == BAND_MID && lb != BAND_LOW)
                ps = PLANT_HAPPY;
            else if (mb == BAND_LOW || lb == BAND_LOW)
                ps = PLANT_STRESSED;
            else if (mb == BAND_HIGH)
                ps = PLANT_ALERT;
            else
                ps = PLANT_NEUTRAL;
            case (ps)
                PLANT_HAPPY:                 pc = PAT_HAPPY;
                PLANT_STRESSED, PLANT_ALERT: pc = PAT_ALERT;
                default:                     pc = (mb == BAND_MID) ? PAT_RELAXED : PAT_NEUTRAL;
            endcase
            want.moisture_band = mb;
            want.light_band    = lb;
            want.plant_state   = ps;
            want.pattern_code  = pc;
            expected_q.push_back(want);
        endfunction

        task report_mismatch(string msg);
            fail_count++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report_mismatch("result item with none expected");
                return;
            end
            want = expected_q.pop_front();
            compare_field("moisture_average", got.moisture_average, want.moisture_average);
            compare_field("light_average", got.light_average, want.light_average);
            compare_field("moisture_band", got.moisture_band, want.moisture_band);
            compare_field("light_band", got.light_band, want.light_band);
            compare_field("plant_state", got.plant_state, want.plant_state);
            compare_field("pattern_code", got.pattern_code, want.pattern_code);
        endtask

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    // ---------------------------------------------------------------
    // block hookup
    // ---------------------------------------------------------------
    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    t_in_item                      i_in_item;
    logic                          o_out_valid;
    logic                          i_out_stall;
    t_out_item                     o_out_item;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     i_cfg_index;
    logic [LEVEL_BITS-1:0]         i_cfg_data;

    int unsigned       cycle_count = 0;
    average_scoreboard sb;

    dual_sensor_average_and_classify dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly no gap, some short ones, a rare long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // sample value aimed at a threshold edge, a field extreme or anywhere
    function automatic logic [SAMPLE_FIELD_BITS-1:0] near_level(t_levels lv);
        case ($urandom_range(0, 6))
            0:       return lv.low - 1'b1;
            1:       return lv.low;
            2:       return lv.high;
            3:       return lv.high + 1'b1;
            4:       return SAMPLE_MAX;
            5:       return '0;
            default: return SAMPLE_FIELD_BITS'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // monitor: every handshake is sampled on the clock edge it completes at
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_level(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                sb.note_input(i_in_item);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_item);
        end
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side backpressure: open runs, some long, broken by stalls
    initial begin : out_stall_gen
        int unsigned run_len;
        int unsigned hold_len;
        i_out_stall = 1'b0;
        forever begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            repeat (run_len) @(posedge i_clk);
            hold_len = pick_gap();
            if (hold_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // valid stays up after the handshake unless a gap is drawn, so the next item can follow at once
    task automatic feed_sample(logic [SAMPLE_FIELD_BITS-1:0] m, logic [SAMPLE_FIELD_BITS-1:0] l,
                               bit burst);
        int unsigned gap;
        t_in_item    it;
        it.moisture_sample = m;
        it.light_sample    = l;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [LEVEL_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_levels(t_levels ml, t_levels ll);
        write_reg(CFG_MOIST_DRY, ml.low);
        write_reg(CFG_MOIST_WET, ml.high);
        write_reg(CFG_LIGHT_DARK, ll.low);
        write_reg(CFG_LIGHT_BRIGHT, ll.high);
        // last, so an index past the map that aliases onto a level shows up
        write_reg(CFG_INDEX_BITS'(CFG_LIGHT_BRIGHT + 1 + $urandom_range(0, 3)),
                  LEVEL_BITS'($urandom_range(0, LEVEL_MAX)));
        i_cfg_valid <= 1'b0;
    endtask

    // hold off until every predicted item is back, then let the pipe settle
    task automatic wait_idle();
        int unsigned waited;
        waited = 0;
        while (sb.pending() != 0 && waited < IDLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d result items never arrived", sb.pending()));
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly steady runs (at least a window long so the mean sits on the
    // chosen value, often a threshold edge) mixed with short noise bursts
    task automatic run_random(int unsigned count);
        int unsigned                  hold_left;
        int unsigned                  burst_left;
        bit                           steady;
        logic [SAMPLE_FIELD_BITS-1:0] m_val;
        logic [SAMPLE_FIELD_BITS-1:0] l_val;
        hold_left  = 0;
        burst_left = 0;
        steady     = 1'b0;
        m_val      = '0;
        l_val      = '0;
        for (int unsigned n = 0; n < count; n++) begin
            if (hold_left == 0) begin
                steady    = ($urandom_range(0, 9) < 7);
                hold_left = steady ? $urandom_range(WIN_LEN, WIN_LEN + 4) : $urandom_range(1, 4);
                m_val     = near_level(sb.moist_lv);
                l_val     = near_level(sb.light_lv);
            end
            if (!steady) begin
                m_val = SAMPLE_FIELD_BITS'($urandom_range(0, SAMPLE_MAX));
                l_val = SAMPLE_FIELD_BITS'($urandom_range(0, SAMPLE_MAX));
            end
            // occasional stretch of back-to-back items
            if (burst_left == 0 && $urandom_range(0, 19) == 0)
                burst_left = $urandom_range(20, 60);
            feed_sample(m_val, l_val, burst_left != 0);
            hold_left--;
            if (burst_left != 0)
                burst_left--;
        end
        i_in_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        t_levels ml;
        t_levels ll;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset levels: warm-up from zeroed windows, field extremes
        feed_sample('0, '0, 1'b0);
        feed_sample(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        feed_sample(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        feed_sample(12'hAAA, 12'h555, 1'b0);
        feed_sample(12'h555, 12'hAAA, 1'b1);
        // a full window of each: happy, then wet so alert, then dark so stressed
        repeat (WIN_LEN) feed_sample(12'd2000, 12'd2000, 1'b0);
        repeat (WIN_LEN) feed_sample(SAMPLE_MAX, 12'd2000, 1'b1);
        repeat (WIN_LEN) feed_sample(12'd2000, 12'd500, 1'b0);
        i_in_valid <= 1'b0;
        wait_idle();

        // random phases, each under its own threshold setting
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin  // all levels at the floor
                    ml = '{low: '0, high: '0};
                    ll = '{low: '0, high: '0};
                end
                1: begin  // all levels at the ceiling
                    ml = '{low: LEVEL_MAX, high: LEVEL_MAX};
                    ll = '{low: LEVEL_MAX, high: LEVEL_MAX};
                end
                2: begin  // crossed levels, low above high
                    ml = '{low: LEVEL_MAX, high: '0};
                    ll = '{low: LEVEL_MAX, high: '0};
                end
                3: begin  // back to the defaults
                    ml = '{low: MOIST_DRY_RESET, high: MOIST_WET_RESET};
                    ll = '{low: LIGHT_DARK_RESET, high: LIGHT_BRIGHT_RESET};
                end
                default: begin
                    ml.low  = LEVEL_BITS'($urandom_range(0, LEVEL_MAX));
                    ml.high = LEVEL_BITS'($urandom_range(0, LEVEL_MAX));
                    ll.low  = LEVEL_BITS'($urandom_range(0, LEVEL_MAX));
                    ll.high = LEVEL_BITS'($urandom_range(0, LEVEL_MAX));
                end
            endcase
            program_levels(ml, ll);
            if (ph == 4) begin
                // sender holds back mid-phase until the pipe has drained
                run_random(120);
                wait_idle();
                run_random(130);
            end else begin
                run_random(250);
            end
            wait_idle();
        end

        if (sb.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
